### design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/skf_pkg.sv
package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned GainW    = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned OutDataW = 120;
  localparam int unsigned DivSteps = 17;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [GainW-1:0] OneQ16 = 17'h10000;

  localparam logic [DataW-1:0] ProcNoiseRst = 32'd655;
  localparam logic [DataW-1:0] MeasNoiseRst = 32'd6554;
  localparam logic [DataW-1:0] InitErrRst   = 32'd65536;
  localparam logic [DataW-1:0] InitEstRst   = 32'd0;

  typedef enum logic {
    OP_UPDATE  = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROC_NOISE = 2'd0,
    CFG_MEAS_NOISE = 2'd1,
    CFG_INIT_ERR   = 2'd2,
    CFG_INIT_EST   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DENOM,
    ST_DIV,
    ST_MULT,
    ST_COMMIT,
    ST_RESTART
  } state_e;

  typedef struct packed {
    logic capture;
    logic pred;
    logic denom;
    logic div_step;
    logic div_first;
    logic mult;
    logic commit_upd;
    logic commit_rst;
  } skf_cmd_t;

endpackage

### design/skf_ctrl.sv
module skf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output skf_pkg::skf_cmd_t cmd_o
);
  import skf_pkg::*;

  state_e               state_q, state_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (op_e'(in_op_i) == OP_RESTART) ? ST_RESTART : ST_PRED;
        end
      end
      ST_PRED: begin
        cmd_o.pred = 1'b1;
        state_d    = ST_DENOM;
      end
      ST_DENOM: begin
        cmd_o.denom = 1'b1;
        cnt_d       = '0;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_MULT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The state is only updated once the result register can take it.
        if (out_free) begin
          cmd_o.commit_upd = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_RESTART: begin
        if (out_free) begin
          cmd_o.commit_rst = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/skf_dp.sv
module skf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  skf_pkg::skf_cmd_t                    cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [skf_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [skf_pkg::DataW-1:0]            cfg_wdata_i,
  input  logic [skf_pkg::DataW-1:0]            meas_i,
  output logic [skf_pkg::OutDataW-1:0]         out_data_o
);
  import skf_pkg::*;

  // Configuration and filter state.
  logic        [DataW-1:0] proc_noise_q, meas_noise_q, init_err_q;
  logic signed [DataW-1:0] init_est_q;
  logic signed [DataW-1:0] x_q;
  logic        [DataW-1:0] p_q;

  // Working registers.
  logic signed [DataW-1:0] meas_q;
  logic        [DataW-1:0] ppred_q;
  logic        [DataW:0]   denom_q;
  logic signed [DataW:0]   innov_q;
  logic        [DataW:0]   rem_q;
  logic        [GainW-1:0] quo_q;
  logic        [GainW-1:0] gain_q;
  logic signed [DataW+GainW+1:0] corr_prod_q;
  logic        [DataW+GainW-1:0] p_prod_q;

  // Result register.
  logic signed [DataW-1:0] out_prior_q, out_filt_q;
  logic        [GainW-1:0] out_gain_q;
  logic        [DataW-1:0] out_var_q;

  logic        [DataW:0]   psum;
  logic        [DataW-1:0] ppred_d;
  logic        [DataW+1:0] trial;
  logic                    ge;
  logic        [DataW+1:0] rem_next;
  logic        [GainW-1:0] gain_w;
  logic        [GainW-1:0] one_m_gain;
  logic signed [DataW+GainW+1:0] corr_prod_d;
  logic        [DataW+GainW-1:0] p_prod_d;
  logic signed [DataW+2:0] corr;
  logic signed [DataW+3:0] x_sum;
  logic signed [DataW-1:0] x_new;
  logic        [DataW-1:0] p_new;

  assign psum    = {1'b0, p_q} + {1'b0, proc_noise_q};
  assign ppred_d = psum[DataW] ? '1 : psum[DataW-1:0];

  // Restoring division of ppred * 2^16 by the 33-bit divisor, one bit a step.
  assign trial    = {rem_q, cmd_i.div_first ? ppred_q[0] : 1'b0};
  assign ge       = (trial >= {1'b0, denom_q});
  assign rem_next = ge ? (trial - {1'b0, denom_q}) : trial;

  // A zero divisor only arises with ppred and R both zero; the gain is then zero.
  assign gain_w      = (denom_q == '0) ? '0 : quo_q;
  assign one_m_gain  = OneQ16 - gain_w;
  assign corr_prod_d = innov_q * $signed({1'b0, gain_w});
  assign p_prod_d    = (DataW+GainW)'(ppred_q) * (DataW+GainW)'(one_m_gain);

  // An arithmetic shift by 16 is the floor of the scaled correction.
  assign corr  = corr_prod_q[DataW+GainW+1:16];
  assign x_sum = (DataW+4)'(x_q) + (DataW+4)'(corr);
  always_comb begin
    if (x_sum[DataW+3:DataW-1] == '0 || x_sum[DataW+3:DataW-1] == '1) begin
      x_new = x_sum[DataW-1:0];
    end else if (x_sum[DataW+3]) begin
      x_new = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      x_new = {1'b0, {(DataW-1){1'b1}}};
    end
  end
  assign p_new = p_prod_q[DataW+15:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_noise_q <= ProcNoiseRst;
      meas_noise_q <= MeasNoiseRst;
      init_err_q   <= InitErrRst;
      init_est_q   <= InitEstRst;
      x_q          <= InitEstRst;
      p_q          <= InitErrRst;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PROC_NOISE: proc_noise_q <= cfg_wdata_i;
          CFG_MEAS_NOISE: meas_noise_q <= cfg_wdata_i;
          CFG_INIT_ERR:   init_err_q   <= cfg_wdata_i;
          CFG_INIT_EST:   init_est_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.commit_upd) begin
        x_q <= x_new;
        p_q <= p_new;
      end else if (cmd_i.commit_rst) begin
        x_q <= init_est_q;
        p_q <= init_err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meas_q <= meas_i;
    end
    if (cmd_i.pred) begin
      ppred_q <= ppred_d;
    end
    if (cmd_i.denom) begin
      denom_q <= {1'b0, ppred_q} + {1'b0, meas_noise_q};
      innov_q <= (DataW+1)'(meas_q) - (DataW+1)'(x_q);
      rem_q   <= {2'b00, ppred_q[DataW-1:1]};
      quo_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_next[DataW:0];
      quo_q <= {quo_q[GainW-2:0], ge};
    end
    if (cmd_i.mult) begin
      corr_prod_q <= corr_prod_d;
      p_prod_q    <= p_prod_d;
      gain_q      <= gain_w;
    end
    if (cmd_i.commit_upd) begin
      out_prior_q <= x_q;
      out_filt_q  <= x_new;
      out_gain_q  <= gain_q;
      out_var_q   <= p_new;
    end else if (cmd_i.commit_rst) begin
      out_prior_q <= init_est_q;
      out_filt_q  <= init_est_q;
      out_gain_q  <= '0;
      out_var_q   <= init_err_q;
    end
  end

  assign out_data_o = {(OutDataW - 3*DataW - GainW)'(0), out_var_q, out_gain_q,
                       out_filt_q, out_prior_q};

endmodule

### design/scalar_kalman_filter.sv
// Scalar Kalman filter, Q16.16 fixed point. An input request with tuser set
// restarts the filter from the initial_estimate and initial_error registers, and
// its result is committed from ST_RESTART once the output register is free.
// An update request (tuser clear) predicts, computes the gain with a 17-step
// restoring divider, corrects the estimate and variance, and passes through
// prediction, divisor set-up, the quotient bits (one per cycle), the multiplies
// and the commit, in that order. The next request can be taken the cycle after
// the commit. One request is worked on at a time; a new one is taken as soon as
// the previous result has moved to the output register, even if that result has
// not yet been taken downstream. A result still waiting there holds the commit
// of the next. Noise writes are used by the next update; writes to the initial
// estimate and error take effect on the state only at the next restart.
module scalar_kalman_filter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [skf_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [skf_pkg::DataW-1:0]            cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [skf_pkg::DataW-1:0]            s_axis_tdata,  // measurement
  input  logic                                 s_axis_tuser,  // operation
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // prior_estimate, filtered_estimate, kalman_gain, error_variance, zero fill
  output logic [skf_pkg::OutDataW-1:0]         m_axis_tdata
);
  import skf_pkg::*;

  skf_cmd_t cmd;

  skf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  skf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .meas_i      (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### design/skf_checker.sv
`include "assert_macros.svh"

module skf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [skf_pkg::OutDataW-1:0]  m_axis_tdata
);
  import skf_pkg::*;

  logic                             in_req;
  logic                             out_stall;
  logic [DataW-1:0]                 prior_f;
  logic [DataW-1:0]                 filt_f;
  logic [GainW-1:0]                 gain_f;
  logic [OutDataW-3*DataW-GainW-1:0] pad_f;

  assign in_req    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign prior_f   = m_axis_tdata[31:0];
  assign filt_f    = m_axis_tdata[63:32];
  assign gain_f    = m_axis_tdata[80:64];
  assign pad_f     = m_axis_tdata[119:113];

  // A stalled result keeps its valid and its payload.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // Only one request is worked on at a time.
  `ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_req, !s_axis_tready)

  // The gain never exceeds one.
  `ASSERT_IMPLIES(a_gain_range, clk_i, rst_ni, m_axis_tvalid, !(gain_f[16] && (gain_f[15:0] != '0)))

  // With zero gain the estimate is not moved.
  `ASSERT_IMPLIES(a_zero_gain_hold, clk_i, rst_ni, m_axis_tvalid && (gain_f == '0), prior_f == filt_f)

  // The padding above the fields stays zero.
  `ASSERT_IMPLIES(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, pad_f == '0)

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (.*);
